FILE: design/interval_running_statistics_assert.svh
// ----------------------------------------------------------------------------
// Interval running statistics assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to drop them all.
// ----------------------------------------------------------------------------
`ifndef INTERVAL_RUNNING_STATISTICS_ASSERT_SVH
`define INTERVAL_RUNNING_STATISTICS_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check that a condition implies another in the same cycle
`define IRS_ASSERT_IMPL(lbl, ck, rn, a, c) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
        else $error("interval_running_statistics: assertion failed");

// Check that a condition implies another in the next cycle
`define IRS_ASSERT_NEXT(lbl, ck, rn, a, c) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
        else $error("interval_running_statistics: assertion failed");

`else

`define IRS_ASSERT_IMPL(lbl, ck, rn, a, c)
`define IRS_ASSERT_NEXT(lbl, ck, rn, a, c)

`endif

`endif

FILE: design/irs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irs_pkg
// Widths, limits, command codes and control structs shared by the interval
// statistics controller and datapath.
// ----------------------------------------------------------------------------
package irs_pkg;

    // Field and state widths
    localparam int TIME_W        = 32;
    localparam int INTERVAL_BITS = 24;
    localparam int FRAC_BITS     = 8;
    localparam int WEIGHT_BITS   = 16;
    localparam int MEAN_W        = 32;
    localparam int MSQ_W         = 56;
    localparam int CNT_W         = 32;
    localparam int MUL_W         = 32;
    localparam int WIDE_W        = 2 * MUL_W;

    // Serial multiply/divide unit widths
    localparam int PROD_W        = MSQ_W + CNT_W + 1;
    localparam int MCAND_W       = MSQ_W + CNT_W;
    localparam int DIV_STEPS     = PROD_W;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS + 1);

    // Output packing
    localparam int OUT_FIELDS_W  = MEAN_W + MSQ_W + CNT_W + 1;
    localparam int OUT_W         = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W     = OUT_W - OUT_FIELDS_W;

    // Saturation limits
    localparam logic [MEAN_W-1:0] MEAN_MAX     = '1;
    localparam logic [MSQ_W-1:0]  MSQ_MAX      = '1;
    localparam logic [CNT_W-1:0]  CNT_MAX      = '1;
    localparam logic [WIDE_W-1:0] INTERVAL_MAX =
        (WIDE_W'(1) << INTERVAL_BITS) - WIDE_W'(1);
    localparam logic [WIDE_W-1:0] SQ_LIMIT     = WIDE_W'(MSQ_MAX) >> FRAC_BITS;
    localparam logic [WIDE_W-1:0] WEIGHT_ONE   = WIDE_W'(1) << WEIGHT_BITS;

    // Datapath operation codes
    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_CAPTURE  = 4'd1;
    localparam logic [3:0] OP_CLEAR    = 4'd2;
    localparam logic [3:0] OP_ARM      = 4'd3;
    localparam logic [3:0] OP_DELTA    = 4'd4;
    localparam logic [3:0] OP_SQUARE   = 4'd5;
    localparam logic [3:0] OP_WPROD    = 4'd6;
    localparam logic [3:0] OP_LOAD     = 4'd7;
    localparam logic [3:0] OP_MUL_STEP = 4'd8;
    localparam logic [3:0] OP_DIV_STEP = 4'd9;
    localparam logic [3:0] OP_STORE    = 4'd10;
    localparam logic [3:0] OP_COMMIT   = 4'd11;
    localparam logic [3:0] OP_OUTPUT   = 4'd12;

    // Accumulator preload selects
    localparam logic [1:0] PROD_KEEP = 2'd0;
    localparam logic [1:0] PROD_ZERO = 2'd1;
    localparam logic [1:0] PROD_X    = 2'd2;
    localparam logic [1:0] PROD_X2   = 2'd3;

    // Multiplicand selects
    localparam logic [1:0] MCAND_X    = 2'd0;
    localparam logic [1:0] MCAND_X2   = 2'd1;
    localparam logic [1:0] MCAND_MEAN = 2'd2;
    localparam logic [1:0] MCAND_MSQ  = 2'd3;

    // Multiplier selects
    localparam logic [1:0] MPLIER_COUNT = 2'd0;
    localparam logic [1:0] MPLIER_W     = 2'd1;
    localparam logic [1:0] MPLIER_WN    = 2'd2;
    localparam logic [1:0] MPLIER_MEAN  = 2'd3;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] prod_sel;
        logic [1:0] mcand_sel;
        logic [1:0] mplier_sel;
        logic       ema;        // store: take moving-average result
        logic       phase;      // store: 0 = mean, 1 = mean of squares
    } irs_cmd_t;

    typedef struct packed {
        logic clear_item;
        logic armed;
        logic use_ema;
        logic mul_done;
    } irs_status_t;

endpackage

FILE: design/irs_datapath.sv
`timescale 1ns / 1ps
`include "interval_running_statistics_assert.svh"
// ----------------------------------------------------------------------------
// irs_datapath
// Statistics state, interval preparation, shared shift-add multiplier and
// restoring divider, variance and output registers.
// ----------------------------------------------------------------------------
module irs_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [irs_pkg::WEIGHT_BITS-1:0] cfg_data,
    input  logic                          s_tuser,
    input  logic [irs_pkg::TIME_W-1:0]    s_tdata,
    input  irs_pkg::irs_cmd_t             cmd,
    output irs_pkg::irs_status_t          sts,
    output logic [irs_pkg::OUT_W-1:0]     out_data
);

    // Architectural state
    logic [irs_pkg::WEIGHT_BITS-1:0] weight_reg;
    logic                            armed_reg;
    logic [irs_pkg::TIME_W-1:0]      last_time_reg;
    logic [irs_pkg::CNT_W-1:0]       count_reg;
    logic [irs_pkg::MEAN_W-1:0]      mean_reg;
    logic [irs_pkg::MSQ_W-1:0]       msq_reg;

    // Working registers
    logic                            in_clear_reg;
    logic [irs_pkg::TIME_W-1:0]      in_time_reg;
    logic [irs_pkg::INTERVAL_BITS-1:0] d_reg;
    logic [irs_pkg::MEAN_W-1:0]      x_reg;
    logic [irs_pkg::MSQ_W-1:0]       x2_reg;
    logic [irs_pkg::WIDE_W-1:0]      mp_reg;
    logic [irs_pkg::PROD_W-1:0]      prod_reg;
    logic [irs_pkg::MCAND_W-1:0]     mcand_reg;
    logic [irs_pkg::MUL_W-1:0]       mplier_reg;
    logic [irs_pkg::CNT_W-1:0]       rem_reg;

    // Output registers
    logic [irs_pkg::MEAN_W-1:0]      out_mean_reg;
    logic [irs_pkg::MSQ_W-1:0]       out_var_reg;
    logic [irs_pkg::CNT_W-1:0]       out_count_reg;
    logic                            out_ready_reg;

    logic [irs_pkg::CNT_W-1:0]       newc;
    logic [irs_pkg::TIME_W-1:0]      delta;
    logic [irs_pkg::INTERVAL_BITS-1:0] d_sat;
    logic [irs_pkg::WIDE_W-1:0]      x_full;
    logic [irs_pkg::MEAN_W-1:0]      x_sat;
    logic [irs_pkg::MSQ_W-1:0]       x2_sat;
    logic [irs_pkg::MUL_W-1:0]       mul_a;
    logic [irs_pkg::MUL_W-1:0]       mul_b;
    logic [irs_pkg::WIDE_W-1:0]      mul_p;
    logic [irs_pkg::WEIGHT_BITS:0]   wn_full;
    logic [irs_pkg::PROD_W-1:0]      mul_addend;
    logic [irs_pkg::CNT_W:0]         trial;
    logic                            trial_ge;
    logic [irs_pkg::CNT_W:0]         trial_diff;
    logic [irs_pkg::PROD_W-1:0]      store_val;
    logic [irs_pkg::MEAN_W-1:0]      mean_sat;
    logic [irs_pkg::MSQ_W-1:0]       msq_sat;
    logic [irs_pkg::MSQ_W-1:0]       sq;
    logic [irs_pkg::MSQ_W-1:0]       var_val;
    logic [irs_pkg::PROD_W-1:0]      prod_load;
    logic [irs_pkg::MCAND_W-1:0]     mcand_load;
    logic [irs_pkg::MUL_W-1:0]       mplier_load;

    // Saturating count increment
    assign newc = (count_reg == irs_pkg::CNT_MAX) ? count_reg
                                                   : count_reg + irs_pkg::CNT_W'(1);

    // Wrapping interval, clamped to the interval width
    assign delta = in_time_reg - last_time_reg;
    assign d_sat = (irs_pkg::WIDE_W'(delta) > irs_pkg::INTERVAL_MAX)
                 ? irs_pkg::INTERVAL_BITS'(irs_pkg::INTERVAL_MAX)
                 : delta[irs_pkg::INTERVAL_BITS-1:0];

    // Scale interval and its square to fixed point
    assign x_full = irs_pkg::WIDE_W'(d_reg) << irs_pkg::FRAC_BITS;
    assign x_sat  = (x_full > irs_pkg::WIDE_W'(irs_pkg::MEAN_MAX))
                  ? irs_pkg::MEAN_MAX : x_full[irs_pkg::MEAN_W-1:0];
    assign x2_sat = (mp_reg > irs_pkg::SQ_LIMIT)
                  ? irs_pkg::MSQ_MAX
                  : irs_pkg::MSQ_W'(mp_reg << irs_pkg::FRAC_BITS);

    // Share one parallel multiplier between interval square and weight test
    always_comb
    begin
        if (cmd.op == irs_pkg::OP_WPROD)
        begin
            mul_a = irs_pkg::MUL_W'(weight_reg);
            mul_b = newc;
        end
        else
        begin
            mul_a = irs_pkg::MUL_W'(d_reg);
            mul_b = irs_pkg::MUL_W'(d_reg);
        end
    end
    assign mul_p = irs_pkg::WIDE_W'(mul_a) * irs_pkg::WIDE_W'(mul_b);

    assign wn_full = (irs_pkg::WEIGHT_BITS+1)'(irs_pkg::WEIGHT_ONE)
                   - (irs_pkg::WEIGHT_BITS+1)'(weight_reg);

    // Shift-add multiply step
    assign mul_addend = mplier_reg[0] ? irs_pkg::PROD_W'(mcand_reg) : '0;

    // Restoring divide step by the new count
    assign trial      = {rem_reg, prod_reg[irs_pkg::PROD_W-1]};
    assign trial_ge   = (trial >= {1'b0, newc});
    assign trial_diff = trial - {1'b0, newc};

    // Saturate the finished quotient or the scaled weighted sum
    assign store_val = cmd.ema ? (prod_reg >> irs_pkg::WEIGHT_BITS) : prod_reg;
    assign mean_sat  = (store_val > irs_pkg::PROD_W'(irs_pkg::MEAN_MAX))
                     ? irs_pkg::MEAN_MAX : store_val[irs_pkg::MEAN_W-1:0];
    assign msq_sat   = (store_val > irs_pkg::PROD_W'(irs_pkg::MSQ_MAX))
                     ? irs_pkg::MSQ_MAX : store_val[irs_pkg::MSQ_W-1:0];

    // Variance from the squared mean left in the accumulator
    assign sq      = prod_reg[irs_pkg::MSQ_W+irs_pkg::FRAC_BITS-1:irs_pkg::FRAC_BITS];
    assign var_val = (msq_reg > sq) ? (msq_reg - sq) : '0;

    // Operand selection for a load
    always_comb
    begin
        case (cmd.prod_sel)
            irs_pkg::PROD_ZERO: prod_load = '0;
            irs_pkg::PROD_X:    prod_load = irs_pkg::PROD_W'(x_reg);
            irs_pkg::PROD_X2:   prod_load = irs_pkg::PROD_W'(x2_reg);
            default:            prod_load = prod_reg;
        endcase
        case (cmd.mcand_sel)
            irs_pkg::MCAND_X:    mcand_load = irs_pkg::MCAND_W'(x_reg);
            irs_pkg::MCAND_X2:   mcand_load = irs_pkg::MCAND_W'(x2_reg);
            irs_pkg::MCAND_MEAN: mcand_load = irs_pkg::MCAND_W'(mean_reg);
            default:             mcand_load = irs_pkg::MCAND_W'(msq_reg);
        endcase
        case (cmd.mplier_sel)
            irs_pkg::MPLIER_COUNT: mplier_load = count_reg;
            irs_pkg::MPLIER_W:     mplier_load = irs_pkg::MUL_W'(weight_reg);
            irs_pkg::MPLIER_WN:    mplier_load = irs_pkg::MUL_W'(wn_full);
            default:               mplier_load = irs_pkg::MUL_W'(mean_reg);
        endcase
    end

    // Update weight register and statistics state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg    <= '0;
            armed_reg     <= 1'b0;
            last_time_reg <= '0;
            count_reg     <= '0;
            mean_reg      <= '0;
            msq_reg       <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                weight_reg <= cfg_data;
            end
            unique case (cmd.op)
                irs_pkg::OP_CLEAR:
                begin
                    last_time_reg <= '0;
                    count_reg     <= '0;
                    mean_reg      <= '0;
                    msq_reg       <= '0;
                end
                irs_pkg::OP_ARM:
                begin
                    armed_reg     <= 1'b1;
                    last_time_reg <= in_time_reg;
                end
                irs_pkg::OP_STORE:
                begin
                    if (cmd.phase)
                    begin
                        msq_reg <= msq_sat;
                    end
                    else
                    begin
                        mean_reg <= mean_sat;
                    end
                end
                irs_pkg::OP_COMMIT:
                begin
                    count_reg     <= newc;
                    last_time_reg <= in_time_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Advance working registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            irs_pkg::OP_CAPTURE:
            begin
                in_clear_reg <= s_tuser;
                in_time_reg  <= s_tdata;
            end
            irs_pkg::OP_DELTA:
            begin
                d_reg <= d_sat;
            end
            irs_pkg::OP_SQUARE:
            begin
                x_reg  <= x_sat;
                mp_reg <= mul_p;
            end
            irs_pkg::OP_WPROD:
            begin
                x2_reg <= x2_sat;
                mp_reg <= mul_p;
            end
            irs_pkg::OP_LOAD:
            begin
                prod_reg   <= prod_load;
                mcand_reg  <= mcand_load;
                mplier_reg <= mplier_load;
                rem_reg    <= '0;
            end
            irs_pkg::OP_MUL_STEP:
            begin
                prod_reg   <= prod_reg + mul_addend;
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
            end
            irs_pkg::OP_DIV_STEP:
            begin
                rem_reg  <= trial_ge ? trial_diff[irs_pkg::CNT_W-1:0]
                                     : trial[irs_pkg::CNT_W-1:0];
                prod_reg <= {prod_reg[irs_pkg::PROD_W-2:0], trial_ge};
            end
            irs_pkg::OP_OUTPUT:
            begin
                out_mean_reg  <= mean_reg;
                out_var_reg   <= var_val;
                out_count_reg <= count_reg;
                out_ready_reg <= armed_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Status to the controller
    assign sts.clear_item = in_clear_reg;
    assign sts.armed      = armed_reg;
    assign sts.use_ema    = (weight_reg != '0) && (count_reg != '0)
                         && (mp_reg >= irs_pkg::WEIGHT_ONE);
    assign sts.mul_done   = (mplier_reg == '0);

    assign out_data = {{irs_pkg::OUT_PAD_W{1'b0}}, out_ready_reg, out_count_reg,
                       out_var_reg, out_mean_reg};

    `IRS_ASSERT_IMPL(a_div_rem_below_divisor, clk, rst_n, cmd.op == irs_pkg::OP_DIV_STEP, rem_reg < newc)
    `IRS_ASSERT_IMPL(a_count_changes_on_commit_or_clear, clk, rst_n, count_reg != $past(count_reg), $past(cmd.op) == irs_pkg::OP_COMMIT || $past(cmd.op) == irs_pkg::OP_CLEAR)
    `IRS_ASSERT_IMPL(a_armed_never_falls, clk, rst_n, 1'b1, !$fell(armed_reg))

endmodule

FILE: design/irs_ctrl.sv
`timescale 1ns / 1ps
`include "interval_running_statistics_assert.svh"
// ----------------------------------------------------------------------------
// irs_ctrl
// Sequencer for the interval statistics datapath: input and output
// handshakes, update mode choice, multiply and divide step control.
// ----------------------------------------------------------------------------
module irs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  irs_pkg::irs_status_t sts,
    output irs_pkg::irs_cmd_t    cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_SQUARE   = 4'd2;
    localparam logic [3:0] S_WPROD    = 4'd3;
    localparam logic [3:0] S_MODE     = 4'd4;
    localparam logic [3:0] S_LOAD1    = 4'd5;
    localparam logic [3:0] S_MUL1     = 4'd6;
    localparam logic [3:0] S_LOAD2    = 4'd7;
    localparam logic [3:0] S_MUL2     = 4'd8;
    localparam logic [3:0] S_DIV      = 4'd9;
    localparam logic [3:0] S_STORE    = 4'd10;
    localparam logic [3:0] S_COMMIT   = 4'd11;
    localparam logic [3:0] S_VAR_LOAD = 4'd12;
    localparam logic [3:0] S_VAR_MUL  = 4'd13;
    localparam logic [3:0] S_OUT      = 4'd14;

    logic [3:0]                    state_reg;
    logic [3:0]                    state_next;
    logic                          phase_reg;
    logic                          phase_next;
    logic                          ema_reg;
    logic                          ema_next;
    logic [irs_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [irs_pkg::DIV_CNT_W-1:0] div_cnt_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;

    // Next state and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        ema_next       = ema_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        cmd.op         = irs_pkg::OP_NONE;
        cmd.ema        = ema_reg;
        cmd.phase      = phase_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.op     = irs_pkg::OP_CAPTURE;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (sts.clear_item)
                begin
                    cmd.op     = irs_pkg::OP_CLEAR;
                    state_next = S_VAR_LOAD;
                end
                else if (!sts.armed)
                begin
                    cmd.op     = irs_pkg::OP_ARM;
                    state_next = S_VAR_LOAD;
                end
                else
                begin
                    cmd.op     = irs_pkg::OP_DELTA;
                    state_next = S_SQUARE;
                end
            end
            S_SQUARE:
            begin
                cmd.op     = irs_pkg::OP_SQUARE;
                state_next = S_WPROD;
            end
            S_WPROD:
            begin
                cmd.op     = irs_pkg::OP_WPROD;
                state_next = S_MODE;
            end
            S_MODE:
            begin
                phase_next = 1'b0;
                ema_next   = sts.use_ema;
                state_next = S_LOAD1;
            end
            S_LOAD1:
            begin
                // Preload: weighted new sample, or old mean times old count plus sample
                cmd.op       = irs_pkg::OP_LOAD;
                div_cnt_next = '0;
                if (ema_reg)
                begin
                    cmd.prod_sel   = irs_pkg::PROD_ZERO;
                    cmd.mcand_sel  = phase_reg ? irs_pkg::MCAND_X2 : irs_pkg::MCAND_X;
                    cmd.mplier_sel = irs_pkg::MPLIER_W;
                end
                else
                begin
                    cmd.prod_sel   = phase_reg ? irs_pkg::PROD_X2 : irs_pkg::PROD_X;
                    cmd.mcand_sel  = phase_reg ? irs_pkg::MCAND_MSQ : irs_pkg::MCAND_MEAN;
                    cmd.mplier_sel = irs_pkg::MPLIER_COUNT;
                end
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.op = irs_pkg::OP_MUL_STEP;
                if (sts.mul_done)
                begin
                    state_next = ema_reg ? S_LOAD2 : S_DIV;
                end
            end
            S_LOAD2:
            begin
                // Keep the weighted sample, add the old mean times one minus weight
                cmd.op         = irs_pkg::OP_LOAD;
                cmd.prod_sel   = irs_pkg::PROD_KEEP;
                cmd.mcand_sel  = phase_reg ? irs_pkg::MCAND_MSQ : irs_pkg::MCAND_MEAN;
                cmd.mplier_sel = irs_pkg::MPLIER_WN;
                state_next     = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.op = irs_pkg::OP_MUL_STEP;
                if (sts.mul_done)
                begin
                    state_next = S_STORE;
                end
            end
            S_DIV:
            begin
                cmd.op       = irs_pkg::OP_DIV_STEP;
                div_cnt_next = div_cnt_reg + irs_pkg::DIV_CNT_W'(1);
                if (div_cnt_reg == irs_pkg::DIV_CNT_W'(irs_pkg::DIV_STEPS - 1))
                begin
                    state_next = S_STORE;
                end
            end
            S_STORE:
            begin
                cmd.op = irs_pkg::OP_STORE;
                if (!phase_reg)
                begin
                    phase_next = 1'b1;
                    state_next = S_LOAD1;
                end
                else
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.op     = irs_pkg::OP_COMMIT;
                state_next = S_VAR_LOAD;
            end
            S_VAR_LOAD:
            begin
                cmd.op         = irs_pkg::OP_LOAD;
                cmd.prod_sel   = irs_pkg::PROD_ZERO;
                cmd.mcand_sel  = irs_pkg::MCAND_MEAN;
                cmd.mplier_sel = irs_pkg::MPLIER_MEAN;
                state_next     = S_VAR_MUL;
            end
            S_VAR_MUL:
            begin
                cmd.op = irs_pkg::OP_MUL_STEP;
                if (sts.mul_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    cmd.op         = irs_pkg::OP_OUTPUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Advance controller registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= 1'b0;
            ema_reg       <= 1'b0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            ema_reg       <= ema_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

    `IRS_ASSERT_NEXT(a_accept_to_dispatch, clk, rst_n, s_tvalid && s_tready, state_reg == S_DISPATCH)
    `IRS_ASSERT_IMPL(a_result_from_out_state, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == S_OUT)
    `IRS_ASSERT_IMPL(a_div_count_range, clk, rst_n, state_reg == S_DIV, div_cnt_reg < irs_pkg::DIV_CNT_W'(irs_pkg::DIV_STEPS))

endmodule

FILE: design/interval_running_statistics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_running_statistics
// Running mean and variance of the time between arrival events.
// ----------------------------------------------------------------------------
// Usage: each transaction on the s_ channel is one event. tuser = 0 marks an
// arrival at the timestamp in tdata, tuser = 1 clears the statistics (the
// armed flag stays). Every input transaction yields exactly one result
// transaction on the m_ channel with mean, variance, count and ready flag.
// The cfg channel writes the Q0.16 moving-average weight; write it only
// while the block is idle. cfg_ready is always high.
// The cumulative-average update runs a one-bit-per-cycle restoring divider
// over 89 bits twice (mean and mean of squares); the multiplies are
// shift-add, one multiplier bit per cycle.
// One item is processed at a time; s_tready is high only while idle.
// A finished result sits in the output register; the next input is taken
// while it waits, and if m_tready stays low the next result waits too.
// Reset clears the weight, the statistics and the armed flag.
// ----------------------------------------------------------------------------
module interval_running_statistics (
    input  logic                         clk,
    input  logic                         rst_n,
    // Input channel
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [irs_pkg::TIME_W-1:0]   s_tdata,   // [31:0] receive_time
    input  logic                         s_tuser,   // [0] func
    // Result channel
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [31:0] mean_interval, [87:32] interval_variance,
    // [119:88] message_count, [120] stats_ready, [127:121] zero
    output logic [irs_pkg::OUT_W-1:0]    m_tdata,
    // Configuration channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [irs_pkg::WEIGHT_BITS-1:0] cfg_data
);

    irs_pkg::irs_cmd_t    cmd;
    irs_pkg::irs_status_t sts;

    assign cfg_ready = 1'b1;

    irs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    irs_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_data  (m_tdata)
    );

endmodule
